// ===== rtl/cmkx_pkg.sv =====
`timescale 1ns / 1ps

package cmkx_pkg;

   localparam int DATA_W  = 8;
   localparam int POS_W   = 32;
   localparam int WORD_W  = 64;
   localparam int HALF_W  = 32;
   localparam int LANE_W  = 3;
   localparam int GROUP_W = POS_W - LANE_W;
   localparam int CSR_IDX_W = 2;
   localparam int STEP_W  = 4;

   localparam logic [WORD_W-1:0] GOLDEN_MUL = 64'h9e3779b97f4a7c15;
   localparam logic [WORD_W-1:0] DOMAIN_MUL = 64'hd6e8feb86659fd93;
   localparam logic [WORD_W-1:0] FIN_MUL_A  = 64'hbf58476d1ce4e5b9;
   localparam logic [WORD_W-1:0] FIN_MUL_B  = 64'h94d049bb133111eb;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ROOT_KEY   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OBJECT_ID  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DOMAIN_TAG = 2'd2;

   // multiply sequence steps
   localparam logic [STEP_W-1:0] STEP_OID_LO = 4'd0;
   localparam logic [STEP_W-1:0] STEP_OID_HI = 4'd1;
   localparam logic [STEP_W-1:0] STEP_TAG_LO = 4'd2;
   localparam logic [STEP_W-1:0] STEP_TAG_HI = 4'd3;
   localparam logic [STEP_W-1:0] STEP_A_LL   = 4'd4;
   localparam logic [STEP_W-1:0] STEP_A_LH   = 4'd5;
   localparam logic [STEP_W-1:0] STEP_A_HL   = 4'd6;
   localparam logic [STEP_W-1:0] STEP_B_LL   = 4'd7;
   localparam logic [STEP_W-1:0] STEP_B_LH   = 4'd8;
   localparam logic [STEP_W-1:0] STEP_B_HL   = 4'd9;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_MUL,
      ST_ACC,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic              accept;
      logic              load_v;
      logic              mul;
      logic              acc;
      logic              emit;
      logic [STEP_W-1:0] step;
   } dp_cmd_type;

   typedef struct packed {
      logic hit;
      logic base_valid;
      logic out_free;
   } dp_status_type;

   function automatic logic [WORD_W-1:0] xor_shr(input logic [WORD_W-1:0] v, input int sh);
      return v ^ (v >> sh);
   endfunction

endpackage

// ===== rtl/cmkx_req_if.sv =====
`timescale 1ns / 1ps

interface cmkx_req_if;
   logic                            valid;
   logic                            ready;
   logic [cmkx_pkg::DATA_W-1:0]     data_byte;
   logic                            first_byte;
   logic                            last_byte;

   modport source (output valid, output data_byte, output first_byte, output last_byte,
                   input ready);
   modport sink (input valid, input data_byte, input first_byte, input last_byte,
                 output ready);
endinterface

// ===== rtl/cmkx_rsp_if.sv =====
`timescale 1ns / 1ps

interface cmkx_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [cmkx_pkg::DATA_W-1:0]     out_byte;
   logic                            out_last;

   modport source (output valid, output out_byte, output out_last, input ready);
   modport sink (input valid, input out_byte, input out_last, output ready);
endinterface

// ===== rtl/cmkx_csr_if.sv =====
`timescale 1ns / 1ps

interface cmkx_csr_if;
   logic                              valid;
   logic                              ready;
   logic [cmkx_pkg::CSR_IDX_W-1:0]    index;
   logic [cmkx_pkg::WORD_W-1:0]       wdata;

   modport source (output valid, output index, output wdata, input ready);
   modport sink (input valid, input index, input wdata, output ready);
endinterface

// ===== rtl/counter_mode_mix_keystream_xor.sv =====
`timescale 1ns / 1ps
// flow: an accepted beat is looked up; when the key word of its group is cached it goes
//   to emit, else the finalizer steps run from the cached base word, or all steps run
// throughput: one beat at a time; a new group takes six passes through the shared 32x32
//   multiplier once the base word is cached; emit waits while the output holds a result
// a finished result waits in the output register while the next beat is accepted
// reset: synchronous active high; position, key registers and valid flags clear to zero

module counter_mode_mix_keystream_xor (
   input logic      clock,
   input logic      reset,
   cmkx_req_if.sink   req_bus,
   cmkx_rsp_if.source rsp_bus,
   cmkx_csr_if.sink   csr_bus
);
   import cmkx_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   // register writes are always taken
   assign csr_bus.ready = 1'b1;

   // sequencer: lookup, multiply/accumulate steps, emit
   cmkx_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // registers, key word cache, shared multiplier and output register
   cmkx_dpath u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_data_byte  (req_bus.data_byte),
      .req_first_byte (req_bus.first_byte),
      .req_last_byte  (req_bus.last_byte),
      .csr_we         (csr_bus.valid),
      .csr_index      (csr_bus.index),
      .csr_wdata      (csr_bus.wdata),
      .rsp_valid      (rsp_bus.valid),
      .rsp_ready      (rsp_bus.ready),
      .rsp_out_byte   (rsp_bus.out_byte),
      .rsp_out_last   (rsp_bus.out_last)
   );

endmodule

// ===== rtl/cmkx_ctrl.sv =====
`timescale 1ns / 1ps

module cmkx_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  cmkx_pkg::dp_status_type   status,
   output cmkx_pkg::dp_cmd_type      cmd
);
   import cmkx_pkg::*;

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= STEP_OID_LO;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_LOOKUP;
         end
         ST_LOOKUP: begin
            if (status.hit) begin
               state_in = ST_EMIT;
            end else begin
               state_in = ST_MUL;
               step_in  = status.base_valid ? STEP_A_LL : STEP_OID_LO;
            end
         end
         ST_MUL: state_in = ST_ACC;
         ST_ACC: begin
            if (step_ff == STEP_B_HL) begin
               state_in = ST_EMIT;
            end else begin
               state_in = ST_MUL;
               step_in  = step_ff + 1'b1;
            end
         end
         ST_EMIT: begin
            if (status.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ready  = 1'b0;
      cmd        = '0;
      cmd.step   = step_ff;
      case (state_ff)
         ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
         end
         ST_LOOKUP: cmd.load_v = !status.hit && status.base_valid;
         ST_MUL:    cmd.mul = 1'b1;
         ST_ACC:    cmd.acc = 1'b1;
         ST_EMIT:   cmd.emit = status.out_free;
         default:   cmd = '0;
      endcase
   end

endmodule

// ===== rtl/cmkx_dpath.sv =====
`timescale 1ns / 1ps

module cmkx_dpath (
   input  logic                             clock,
   input  logic                             reset,
   input  cmkx_pkg::dp_cmd_type             cmd,
   output cmkx_pkg::dp_status_type          status,
   input  logic [cmkx_pkg::DATA_W-1:0]      req_data_byte,
   input  logic                             req_first_byte,
   input  logic                             req_last_byte,
   input  logic                             csr_we,
   input  logic [cmkx_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [cmkx_pkg::WORD_W-1:0]      csr_wdata,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [cmkx_pkg::DATA_W-1:0]      rsp_out_byte,
   output logic                             rsp_out_last
);
   import cmkx_pkg::*;

   logic [WORD_W-1:0]  root_key_ff;
   logic [HALF_W-1:0]  object_id_ff;
   logic [HALF_W-1:0]  domain_tag_ff;
   logic [POS_W-1:0]   pos_ff;
   logic [POS_W-1:0]   cur_pos_ff;
   logic [DATA_W-1:0]  data_ff;
   logic               last_ff;
   logic [WORD_W-1:0]  base_ff;
   logic               base_valid_ff;
   logic [WORD_W-1:0]  v_ff;
   logic [WORD_W-1:0]  acc_ff;
   logic [WORD_W-1:0]  prod_ff;
   logic [WORD_W-1:0]  word_ff;
   logic [GROUP_W-1:0] word_group_ff;
   logic               word_valid_ff;
   logic               rsp_valid_ff;
   logic [DATA_W-1:0]  out_byte_ff;
   logic               out_last_ff;

   logic [POS_W-1:0]   start_pos;
   logic [WORD_W-1:0]  group_word;
   logic [HALF_W-1:0]  op_a, op_b;
   logic [WORD_W-1:0]  prod_in;
   logic [WORD_W-1:0]  sum;
   logic [WORD_W-1:0]  base_next;
   logic [DATA_W-1:0]  ks_byte;

   assign start_pos  = req_first_byte ? '0 : pos_ff;
   assign group_word = {{(WORD_W-GROUP_W){1'b0}}, cur_pos_ff[POS_W-1:LANE_W]};
   assign sum        = acc_ff + {prod_ff[HALF_W-1:0], {HALF_W{1'b0}}};
   assign base_next  = base_ff ^ sum;
   assign ks_byte    = word_ff[{cur_pos_ff[LANE_W-1:0], 3'b000} +: DATA_W];

   assign status.hit        = word_valid_ff && (word_group_ff == cur_pos_ff[POS_W-1:LANE_W]);
   assign status.base_valid = base_valid_ff;
   assign status.out_free   = !rsp_valid_ff || rsp_ready;

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = out_byte_ff;
   assign rsp_out_last = out_last_ff;

   // operand selection for the shared 32x32 multiplier
   always_comb begin
      case (cmd.step)
         STEP_OID_LO: begin op_a = object_id_ff;          op_b = GOLDEN_MUL[31:0];  end
         STEP_OID_HI: begin op_a = object_id_ff;          op_b = GOLDEN_MUL[63:32]; end
         STEP_TAG_LO: begin op_a = domain_tag_ff;         op_b = DOMAIN_MUL[31:0];  end
         STEP_TAG_HI: begin op_a = domain_tag_ff;         op_b = DOMAIN_MUL[63:32]; end
         STEP_A_LL:   begin op_a = v_ff[HALF_W-1:0];      op_b = FIN_MUL_A[31:0];   end
         STEP_A_LH:   begin op_a = v_ff[HALF_W-1:0];      op_b = FIN_MUL_A[63:32];  end
         STEP_A_HL:   begin op_a = v_ff[WORD_W-1:HALF_W]; op_b = FIN_MUL_A[31:0];   end
         STEP_B_LL:   begin op_a = v_ff[HALF_W-1:0];      op_b = FIN_MUL_B[31:0];   end
         STEP_B_LH:   begin op_a = v_ff[HALF_W-1:0];      op_b = FIN_MUL_B[63:32];  end
         STEP_B_HL:   begin op_a = v_ff[WORD_W-1:HALF_W]; op_b = FIN_MUL_B[31:0];   end
         default:     begin op_a = '0;                    op_b = '0;                end
      endcase
   end

   assign prod_in = {{HALF_W{1'b0}}, op_a} * {{HALF_W{1'b0}}, op_b};

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         root_key_ff   <= '0;
         object_id_ff  <= '0;
         domain_tag_ff <= '0;
         pos_ff        <= '0;
         cur_pos_ff    <= '0;
         base_valid_ff <= 1'b0;
         word_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_ROOT_KEY:   root_key_ff   <= csr_wdata;
               CSR_OBJECT_ID:  object_id_ff  <= csr_wdata[HALF_W-1:0];
               CSR_DOMAIN_TAG: domain_tag_ff <= csr_wdata[HALF_W-1:0];
               default:        root_key_ff   <= root_key_ff;
            endcase
            base_valid_ff <= 1'b0;
            word_valid_ff <= 1'b0;
         end
         if (cmd.accept) begin
            cur_pos_ff <= start_pos;
            pos_ff     <= start_pos + 1'b1;
         end
         if (cmd.acc && cmd.step == STEP_TAG_HI) base_valid_ff <= 1'b1;
         if (cmd.acc && cmd.step == STEP_B_HL)   word_valid_ff <= 1'b1;
         if (cmd.emit)           rsp_valid_ff <= 1'b1;
         else if (rsp_ready)     rsp_valid_ff <= 1'b0;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         data_ff <= req_data_byte;
         last_ff <= req_last_byte;
      end
      if (cmd.mul) prod_ff <= prod_in;
      if (cmd.load_v) v_ff <= xor_shr(base_ff ^ group_word, 30);
      if (cmd.acc) begin
         case (cmd.step)
            STEP_OID_LO, STEP_TAG_LO, STEP_A_LL, STEP_B_LL: acc_ff <= prod_ff;
            STEP_A_LH, STEP_B_LH: acc_ff <= sum;
            STEP_OID_HI: base_ff <= root_key_ff ^ sum;
            STEP_TAG_HI: begin
               base_ff <= base_next;
               v_ff    <= xor_shr(base_next ^ group_word, 30);
            end
            STEP_A_HL: v_ff <= xor_shr(sum, 27);
            STEP_B_HL: begin
               word_ff       <= xor_shr(sum, 31);
               word_group_ff <= cur_pos_ff[POS_W-1:LANE_W];
            end
            default: acc_ff <= acc_ff;
         endcase
      end
      if (cmd.emit) begin
         out_byte_ff <= data_ff ^ ks_byte;
         out_last_ff <= last_ff;
      end
   end

   // a result beat always uses the key word of its own group
   a_emit_group: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> word_valid_ff && word_group_ff == cur_pos_ff[POS_W-1:LANE_W])
      else $error("emit with stale key word");

   // finalizer steps never start from an unbuilt base word
   a_mix_base: assert property (@(posedge clock) disable iff (reset)
      (cmd.mul && cmd.step >= STEP_A_LL) |-> base_valid_ff)
      else $error("mix step without base word");

   // register write drops every cached word
   a_csr_flush: assert property (@(posedge clock) disable iff (reset)
      csr_we |=> !word_valid_ff && !base_valid_ff)
      else $error("cache survived register write");

   // position advances by one per accepted beat
   a_pos_step: assert property (@(posedge clock) disable iff (reset)
      cmd.accept |=> pos_ff == cur_pos_ff + 1'b1)
      else $error("position did not advance");

endmodule

// ===== tb/counter_mode_mix_keystream_xor_test.sv =====
`timescale 1ns / 1ps

module counter_mode_mix_keystream_xor_test;
   import cmkx_pkg::*;

   // index 3 decodes to no register, writes there must leave the key alone
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   localparam int SETTLE_CYCLES  = 30;      // idle time after the last beat drains
   localparam int CYCLE_LIMIT    = 600000;
   localparam int REPORT_MAX     = 10;
   localparam int RANDOM_PHASES  = 8;
   localparam int BEATS_PER_PHASE = 160;

   typedef enum int {
      IDLE_NONE,
      IDLE_SENDER,
      IDLE_RECEIVER,
      IDLE_BOTH
   } idle_mode_type;

   typedef struct packed {
      logic [DATA_W-1:0] out_byte;
      logic              out_last;
   } cipher_beat_type;

   logic clock = 1'b0;
   logic reset;

   cmkx_req_if req_bus ();
   cmkx_rsp_if rsp_bus ();
   cmkx_csr_if csr_bus ();

   counter_mode_mix_keystream_xor u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // shadow copy of the key registers and the byte position
   logic [WORD_W-1:0] root_key_q;
   logic [HALF_W-1:0] object_id_q;
   logic [HALF_W-1:0] domain_tag_q;
   logic [POS_W-1:0]  stream_pos;

   // cipher beats predicted but not yet seen on the result channel
   cipher_beat_type pending_beats[$];

   int mismatch_count;
   int send_idle_pct;
   int rsp_stall_pct;
   int cycle_count = 0;

   always #4 clock = ~clock;

   // splitmix64 output stage
   function automatic logic [WORD_W-1:0] splitmix_finalize(input logic [WORD_W-1:0] v);
      logic [WORD_W-1:0] m;
      m = (v ^ (v >> 30)) * FIN_MUL_A;
      m = (m ^ (m >> 27)) * FIN_MUL_B;
      return m ^ (m >> 31);
   endfunction

   // xor one byte with its keystream byte and advance the position
   function automatic cipher_beat_type encrypt_byte(input logic [DATA_W-1:0] data,
                                                    input logic first, input logic last);
      logic [WORD_W-1:0] base;
      logic [WORD_W-1:0] key_word;
      logic [POS_W-1:0]  pos;
      cipher_beat_type   beat;
      if (first) stream_pos = '0;
      pos = stream_pos;
      base = root_key_q
           ^ ({{(WORD_W-HALF_W){1'b0}}, object_id_q} * GOLDEN_MUL)
           ^ ({{(WORD_W-HALF_W){1'b0}}, domain_tag_q} * DOMAIN_MUL);
      // group index is the position without its lane bits
      key_word = splitmix_finalize(base ^ WORD_W'(pos >> LANE_W));
      // lane 0 takes the low byte of the key word
      beat.out_byte = data ^ key_word[8*pos[LANE_W-1:0] +: DATA_W];
      beat.out_last = last;
      stream_pos = pos + 1'b1;
      return beat;
   endfunction

   function automatic void note_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= REPORT_MAX) $display("mismatch: %s", msg);
   endfunction

   function automatic void set_idling(input idle_mode_type mode);
      send_idle_pct = (mode == IDLE_SENDER) ? 84 : (mode == IDLE_BOTH) ? 25 : 0;
      rsp_stall_pct = (mode == IDLE_RECEIVER) ? 84 : (mode == IDLE_BOTH) ? 25 : 0;
   endfunction

   // one input beat; valid stays high afterwards so the next call can follow back to back
   task automatic send_byte(input logic [DATA_W-1:0] data, input logic first, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.data_byte  <= data;
      req_bus.first_byte <= first;
      req_bus.last_byte  <= last;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      pending_beats.push_back(encrypt_byte(data, first, last));
   endtask

   // register write; the caller drops csr valid after its last write
   task automatic write_reg(input logic [CSR_IDX_W-1:0] index, input logic [WORD_W-1:0] wdata);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= index;
      csr_bus.wdata <= wdata;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      case (index)
         CSR_ROOT_KEY:   root_key_q   = wdata;
         CSR_OBJECT_ID:  object_id_q  = wdata[HALF_W-1:0];
         CSR_DOMAIN_TAG: domain_tag_q = wdata[HALF_W-1:0];
         default: ;
      endcase
   endtask

   // drain all outstanding beats with request valid low, then idle before the next test
   task automatic settle;
      req_bus.valid <= 1'b0;
      while (pending_beats.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [WORD_W-1:0] pick_key_value();
      case ($urandom_range(3))
         0: return '0;
         1: return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // zero key after reset: byte extremes, flag combinations, continuing past last,
   // restart in the middle of a group
   task automatic test_flag_handling;
      set_idling(IDLE_NONE);
      send_byte(8'h00, 1'b1, 1'b0);
      send_byte(8'hff, 1'b0, 1'b0);
      repeat (6) send_byte(DATA_W'($urandom), 1'b0, 1'b0);
      send_byte(8'h5a, 1'b0, 1'b1);            // first beat of group one, ends the buffer
      // no first flag after last, keystream keeps running
      send_byte(8'h00, 1'b0, 1'b0);
      send_byte(8'hff, 1'b0, 1'b1);
      // restart mid group, then a one-byte buffer
      send_byte(8'h33, 1'b1, 1'b0);
      send_byte(8'hcc, 1'b1, 1'b1);
      settle;
   endtask

   // all-ones registers with junk in the upper bits, writes to the unused index,
   // and a key change in the middle of a buffer
   task automatic test_register_access;
      set_idling(IDLE_NONE);
      write_reg(CSR_ROOT_KEY, '1);
      write_reg(CSR_OBJECT_ID, '1);
      write_reg(CSR_DOMAIN_TAG, '1);
      write_reg(CSR_UNUSED, {$urandom, $urandom});
      csr_bus.valid <= 1'b0;
      send_byte(8'h00, 1'b1, 1'b0);
      repeat (3) send_byte(DATA_W'($urandom), 1'b0, 1'b0);
      settle;
      // new root key applies from the next byte, position carries on
      write_reg(CSR_ROOT_KEY, {$urandom, $urandom});
      csr_bus.valid <= 1'b0;
      repeat (4) send_byte(DATA_W'($urandom), 1'b0, 1'b0);
      send_byte(8'hff, 1'b0, 1'b1);
      settle;
      write_reg(CSR_UNUSED, '1);
      csr_bus.valid <= 1'b0;
      send_byte(8'ha5, 1'b0, 1'b0);
      send_byte(8'h5a, 1'b0, 1'b1);
      settle;
   endtask

   // random keys per phase, mostly well-formed buffers with some loose flag noise
   task automatic test_random_buffers;
      int sent;
      int len;
      bit framed;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         set_idling(idle_mode_type'(phase % 4));
         write_reg(CSR_ROOT_KEY, pick_key_value());
         write_reg(CSR_OBJECT_ID, pick_key_value());
         write_reg(CSR_DOMAIN_TAG, pick_key_value());
         if ($urandom_range(1) == 1) write_reg(CSR_UNUSED, {$urandom, $urandom});
         csr_bus.valid <= 1'b0;
         sent = 0;
         while (sent < BEATS_PER_PHASE) begin
            len    = ($urandom_range(9) == 0) ? $urandom_range(25, 64) : $urandom_range(1, 24);
            framed = ($urandom_range(99) < 85);
            for (int i = 0; i < len; i++) begin
               if (framed)
                  send_byte(DATA_W'($urandom), i == 0, i == len - 1);
               else
                  send_byte(DATA_W'($urandom), $urandom_range(7) == 0, $urandom_range(7) == 0);
            end
            sent += len;
         end
         settle;
      end
   endtask

   // receiver back pressure
   always @(posedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // compare every accepted result beat against the oldest prediction
   always @(posedge clock) begin
      cipher_beat_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_beats.size() == 0) begin
            note_mismatch($sformatf("unexpected beat out_byte=%02h out_last=%0b",
                                    rsp_bus.out_byte, rsp_bus.out_last));
         end else begin
            want = pending_beats.pop_front();
            if (rsp_bus.out_byte !== want.out_byte)
               note_mismatch($sformatf("out_byte expected %02h actual %02h",
                                       want.out_byte, rsp_bus.out_byte));
            if (rsp_bus.out_last !== want.out_last)
               note_mismatch($sformatf("out_last expected %0b actual %0b",
                                       want.out_last, rsp_bus.out_last));
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      reset              = 1'b1;
      req_bus.valid      = 1'b0;
      req_bus.data_byte  = '0;
      req_bus.first_byte = 1'b0;
      req_bus.last_byte  = 1'b0;
      csr_bus.valid      = 1'b0;
      csr_bus.index      = CSR_ROOT_KEY;
      csr_bus.wdata      = '0;
      send_idle_pct      = 0;
      rsp_stall_pct      = 0;
      mismatch_count     = 0;
      root_key_q         = '0;
      object_id_q        = '0;
      domain_tag_q       = '0;
      stream_pos         = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_flag_handling;
      test_register_access;
      test_random_buffers;
      settle;

      if (mismatch_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
